### sv/kpt_pkg.sv
`default_nettype none
package kpt_pkg;

    localparam int POS_FRAC_BITS_DEF = 16;
    localparam int VAR_FRAC_BITS_DEF = 40;
    localparam int ANGLE_BITS_DEF    = 16;

    localparam int POS_W   = 32;
    localparam int VAR_W   = 48;
    localparam int ANG_W   = 16;
    localparam int CFG_W   = 48;
    localparam int CORDIC_N = 24;

    localparam logic [VAR_W-1:0] VAR_MAX           = {VAR_W{1'b1}};
    localparam logic [VAR_W-1:0] PROCESS_NOISE_RST = 48'd1099511628;
    localparam logic [VAR_W-1:0] MEAS_NOISE_RST    = 48'd10995116;
    localparam logic signed [33:0] CORDIC_GAIN     = 34'sd652032874;
    localparam logic signed [33:0] Q30_ONE         = 34'sd1073741824;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_PREDICT = 2'd1,
        OP_UPDATE  = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [0:0] {
        CFG_PROCESS_NOISE = 1'b0,
        CFG_MEAS_NOISE    = 1'b1
    } cfg_idx_t;

    function automatic logic [29:0] atan_lut(input logic [4:0] i);
        logic [29:0] r;
        begin
            unique case (i)
                5'd0:  r = 30'd536870912;
                5'd1:  r = 30'd316933406;
                5'd2:  r = 30'd167458907;
                5'd3:  r = 30'd85004756;
                5'd4:  r = 30'd42667331;
                5'd5:  r = 30'd21354465;
                5'd6:  r = 30'd10679838;
                5'd7:  r = 30'd5340245;
                5'd8:  r = 30'd2670163;
                5'd9:  r = 30'd1335087;
                5'd10: r = 30'd667544;
                5'd11: r = 30'd333772;
                5'd12: r = 30'd166886;
                5'd13: r = 30'd83443;
                5'd14: r = 30'd41722;
                5'd15: r = 30'd20861;
                5'd16: r = 30'd10430;
                5'd17: r = 30'd5215;
                5'd18: r = 30'd2608;
                5'd19: r = 30'd1304;
                5'd20: r = 30'd652;
                5'd21: r = 30'd326;
                5'd22: r = 30'd163;
                5'd23: r = 30'd81;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

### sv/kpt_cordic.sv
`default_nettype none
module kpt_cordic
    import kpt_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [ANG_W-1:0]    angle,
    output logic                     done,
    output logic signed [33:0]       cos_out,
    output logic signed [33:0]       sin_out
);

    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic [4:0]         i_reg, i_next;
    logic               busy_reg, busy_next, flip_reg, flip_next;
    logic               done_reg, done_next;
    logic [31:0]        ang_ext;
    logic [31:0]        ph;
    logic [31:0]        ph_f;
    logic signed [33:0] dx, dy, cx, cy, atan_v;

    function automatic logic signed [33:0] clamp1(input logic signed [33:0] v);
        begin
            if (v > Q30_ONE)
                return Q30_ONE;
            else if (v < -Q30_ONE)
                return -Q30_ONE;
            return v;
        end
    endfunction

    always_comb
    begin
        ang_ext = 32'(angle);
        ph     = 32'(ang_ext[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
        ph_f   = ph + ((ph[31] ^ ph[30]) ? 32'h8000_0000 : 32'h0);
        dx     = y_reg >>> i_reg;
        dy     = x_reg >>> i_reg;
        atan_v = 34'(atan_lut(i_reg));
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        i_next = i_reg; busy_next = busy_reg; flip_next = flip_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = 34'(signed'(ph_f));
            i_next    = '0;
            busy_next = 1'b1;
            flip_next = ph[31] ^ ph[30];
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - dx; y_next = y_reg + dy; z_next = z_reg - atan_v;
            end
            else
            begin
                x_next = x_reg + dx; y_next = y_reg - dy; z_next = z_reg + atan_v;
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(CORDIC_N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        cx      = clamp1(x_reg);
        cy      = clamp1(y_reg);
        cos_out = flip_reg ? -cx : cx;
        sin_out = flip_reg ? -cy : cy;
        done    = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
            flip_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
            flip_reg <= flip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

endmodule
`default_nettype wire

### sv/kpt_div.sv
`default_nettype none
module kpt_div
    import kpt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [VAR_W:0]   num,
    input  wire logic [VAR_W:0]   den,
    output logic                  done,
    output logic [30:0]           quot
);

    // restoring divide, 31 quotient bits, one per cycle
    logic [VAR_W+1:0] rem_reg, rem_next, rem_sh;
    logic [VAR_W:0]   den_reg, den_next;
    logic [30:0]      q_reg, q_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;

    always_comb
    begin
        rem_next = rem_reg; den_next = den_reg; q_next = q_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        rem_sh   = (cnt_reg == 5'd0) ? rem_reg : {rem_reg[VAR_W:0], 1'b0};
        if (start)
        begin
            rem_next  = {1'b0, num};
            den_next  = den;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (den_reg == '0)
            begin
                q_next    = '0;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_next = rem_sh - {1'b0, den_reg};
                    q_next   = {q_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[29:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd30)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

endmodule
`default_nettype wire

### sv/kalman_point_tracker_2d_top.sv
// Sequence, accept edge to out_valid: init and the unused opcode go straight to the output;
// predict runs 24 CORDIC iterations, then multiply steps on one shared 35x35 multiplier;
// update runs a 31-step restoring divider, then multiply steps.
// Throughput: one transaction at a time; in_ready is low from accept until the result is
// taken, so the earliest accept of the next item is in the cycle after the result is taken.
// Reset: asynchronous active low; estimates zero, variances one, noise registers default.
`default_nettype none
module kalman_point_tracker_2d_top
    import kpt_pkg::*;
#(
    parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF,
    parameter int VAR_FRAC_BITS = VAR_FRAC_BITS_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF
)(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              opcode,
    input  wire logic signed [POS_W-1:0] in_x,
    input  wire logic signed [POS_W-1:0] in_y,
    input  wire logic [ANG_W-1:0]        angle,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [POS_W-1:0]      out_x,
    output logic signed [POS_W-1:0]      out_y
);

    typedef enum logic [3:0] {
        S_IDLE, S_CORDIC, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8,
        S_PFIN, S_DIV, S_U1, S_U2, S_U3, S_OUT
    } state_t;

    localparam logic [VAR_W-1:0] VAR_ONE =
        (VAR_FRAC_BITS >= VAR_W) ? VAR_MAX : VAR_W'(64'd1 << VAR_FRAC_BITS);
    localparam int UNUSED_POS = POS_FRAC_BITS;

    state_t state_reg, state_next;
    logic [VAR_W-1:0] pn_reg, mn_reg;
    logic signed [POS_W-1:0] est_x_reg, est_x_next, est_y_reg, est_y_next;
    logic signed [POS_W-1:0] pred_x_reg, pred_x_next, pred_y_reg, pred_y_next;
    logic [VAR_W-1:0] vpost_reg, vpost_next, vpred_reg, vpred_next;
    logic [1:0] op_reg, op_next;
    logic signed [POS_W-1:0] ix_reg, ix_next, iy_reg, iy_next;
    logic [ANG_W-1:0] ang_reg, ang_next;
    logic signed [33:0] c_reg, c_next, s_reg, s_next;
    logic signed [69:0] acc_reg, acc_next;
    logic signed [69:0] prod_reg;
    logic signed [34:0] ma, mb;
    logic [30:0] k_reg, k_next;
    logic [VAR_W-1:0] t_reg, t_next;
    logic signed [POS_W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic ov_reg, ov_next;
    logic cor_start, div_start, cor_done, div_done;
    logic signed [33:0] cor_c, cor_s;
    logic [30:0] div_q;
    logic [VAR_W:0] den_w;
    logic signed [69:0] rnd, sum_w;
    logic signed [64:0] r64;
    logic [VAR_W:0] vsum;

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [69:0] v);
        begin
            if (v > 70'sd2147483647)
                return 32'sh7FFF_FFFF;
            else if (v < -70'sd2147483648)
                return 32'sh8000_0000;
            return v[31:0];
        end
    endfunction

    kpt_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cor_start), .angle(ang_next),
        .done(cor_done), .cos_out(cor_c), .sin_out(cor_s)
    );

    assign den_w = {1'b0, vpred_reg} + {1'b0, mn_reg};

    kpt_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num({1'b0, vpred_reg}), .den(den_w), .done(div_done), .quot(div_q)
    );

    // shared multiplier, registered product
    always_ff @(posedge clk)
    begin
        prod_reg <= 70'(ma) * 70'(mb);
    end

    assign rnd   = 70'sd536870912;
    assign sum_w = acc_reg + prod_reg;

    always_comb
    begin
        state_next = state_reg;
        est_x_next = est_x_reg; est_y_next = est_y_reg;
        pred_x_next = pred_x_reg; pred_y_next = pred_y_reg;
        vpost_next = vpost_reg; vpred_next = vpred_reg;
        op_next = op_reg; ix_next = ix_reg; iy_next = iy_reg; ang_next = ang_reg;
        c_next = c_reg; s_next = s_reg; acc_next = acc_reg; k_next = k_reg;
        t_next = t_reg;
        ox_next = ox_reg; oy_next = oy_reg; ov_next = ov_reg;
        ma = '0; mb = '0;
        cor_start = 1'b0; div_start = 1'b0;
        r64 = '0; vsum = '0;
        in_ready = (state_reg == S_IDLE) && !ov_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    op_next = opcode; ix_next = in_x; iy_next = in_y; ang_next = angle;
                    unique case (opcode_t'(opcode))
                        OP_INIT:
                        begin
                            est_x_next = in_x; pred_x_next = in_x;
                            est_y_next = in_y; pred_y_next = in_y;
                            vpost_next = VAR_ONE; vpred_next = VAR_ONE;
                            ox_next = in_x; oy_next = in_y;
                            state_next = S_OUT;
                        end
                        OP_PREDICT: state_next = S_CORDIC;
                        OP_UPDATE:  state_next = S_DIV;
                        OP_NONE:
                        begin
                            ox_next = est_x_reg; oy_next = est_y_reg;
                            state_next = S_OUT;
                        end
                    endcase
                    if (opcode_t'(opcode) == OP_PREDICT)
                        cor_start = 1'b1;
                    if (opcode_t'(opcode) == OP_UPDATE)
                        div_start = 1'b1;
                end
            end
            S_CORDIC:
            begin
                if (cor_done)
                begin
                    c_next = cor_c; s_next = cor_s;
                    state_next = S_M1;
                end
            end
            S_M1: begin ma = 35'(c_reg); mb = 35'(est_x_reg); state_next = S_M2; end
            S_M2:
            begin
                acc_next = prod_reg + rnd;
                ma = 35'(-s_reg); mb = 35'(est_y_reg); state_next = S_M3;
            end
            S_M3:
            begin
                r64 = 65'(sum_w >>> 30);
                pred_x_next = sat32(70'(r64) + 70'(ix_reg));
                ma = 35'(s_reg); mb = 35'(est_x_reg); state_next = S_M4;
            end
            S_M4:
            begin
                acc_next = prod_reg + rnd;
                ma = 35'(c_reg); mb = 35'(est_y_reg); state_next = S_M5;
            end
            S_M5:
            begin
                r64 = 65'(sum_w >>> 30);
                pred_y_next = sat32(70'(r64) + 70'(iy_reg));
                ma = 35'(c_reg); mb = 35'(c_reg); state_next = S_M6;
            end
            S_M6:
            begin
                // c2 in k_reg (at most 2^30 fits 31 bits)
                k_next = 31'((prod_reg + rnd) >>> 30);
                state_next = S_M7;
            end
            S_M7:
            begin
                ma = 35'({1'b0, vpost_reg[47:24]}); mb = 35'({4'd0, k_reg});
                state_next = S_M8;
            end
            S_M8:
            begin
                acc_next = prod_reg;
                ma = 35'({1'b0, vpost_reg[23:0]}); mb = 35'({4'd0, k_reg});
                state_next = S_PFIN;
            end
            S_PFIN:
            begin
                vsum = 49'(acc_reg >>> 6)
                     + 49'((((acc_reg & 70'sd63) <<< 24) + prod_reg) >>> 30)
                     + {1'b0, pn_reg};
                vpred_next = vsum[VAR_W] ? VAR_MAX : vsum[VAR_W-1:0];
                ox_next = pred_x_reg; oy_next = pred_y_reg;
                state_next = S_OUT;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    k_next = div_q;
                    state_next = S_U1;
                end
            end
            S_U1:
            begin
                ma = 35'(ix_reg) - 35'(pred_x_reg); mb = 35'({4'd0, k_reg});
                state_next = S_U2;
            end
            S_U2:
            begin
                est_x_next = sat32(70'(pred_x_reg) + ((prod_reg + rnd) >>> 30));
                ma = 35'(iy_reg) - 35'(pred_y_reg); mb = 35'({4'd0, k_reg});
                t_next = VAR_W'(31'h4000_0000 - k_reg);
                state_next = S_U3;
            end
            S_U3:
            begin
                est_y_next = sat32(70'(pred_y_reg) + ((prod_reg + rnd) >>> 30));
                ma = 35'({1'b0, vpred_reg[47:24]}); mb = 35'(t_reg);
                state_next = S_M8;
                op_next = OP_UPDATE;
                k_next = 31'(t_reg);
            end
            S_OUT:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // update path reuses S_M8/S_PFIN for var_post
        if (op_reg == OP_UPDATE && state_reg == S_M8)
            ma = 35'({1'b0, vpred_reg[23:0]});
        if (op_reg == OP_UPDATE && state_reg == S_PFIN)
        begin
            vpred_next = vpred_reg;
            vpost_next = vsum[VAR_W-1:0] - pn_reg;
            ox_next = est_x_reg; oy_next = est_y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pn_reg <= PROCESS_NOISE_RST;
            mn_reg <= MEAS_NOISE_RST;
            est_x_reg <= '0; est_y_reg <= '0;
            pred_x_reg <= '0; pred_y_reg <= '0;
            vpost_reg <= VAR_ONE; vpred_reg <= VAR_ONE;
            ov_reg <= 1'b0;
            op_reg <= OP_INIT;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_PROCESS_NOISE: pn_reg <= cfg_data;
                    CFG_MEAS_NOISE:    mn_reg <= cfg_data;
                endcase
            end
            est_x_reg <= est_x_next; est_y_reg <= est_y_next;
            pred_x_reg <= pred_x_next; pred_y_reg <= pred_y_next;
            vpost_reg <= vpost_next; vpred_reg <= vpred_next;
            ov_reg <= ov_next;
            op_reg <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ix_reg <= ix_next; iy_reg <= iy_next; ang_reg <= ang_next;
        c_reg <= c_next; s_reg <= s_next; acc_reg <= acc_next; k_reg <= k_next;
        t_reg <= t_next; ox_reg <= ox_next; oy_reg <= oy_next;
    end

    assign out_valid = ov_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;

endmodule
`default_nettype wire
